[hw/rtl/crfc_pkg.sv]
// Shared types and constants for the receive-side connection flow-control core.
// Holds the payload structs, event and status codes, and the register index map.
// No dependencies.
package crfc_pkg;

    localparam int OFFSET_BITS    = 62;
    localparam int TIME_BITS      = 48;
    localparam int RTT_BITS       = 24;
    localparam int FREQ_BITS      = 8;
    localparam int FUNC_BITS      = 3;
    localparam int STATUS_BITS    = 2;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = OFFSET_BITS;

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
    localparam logic [OFFSET_BITS-1:0] INITIAL_WINDOW_RESET = OFFSET_BITS'(1048576);
    localparam logic [FREQ_BITS-1:0]   RTT_FREQUENCY_RESET    = FREQ_BITS'(1);
    localparam logic [FREQ_BITS-1:0]   WINDOW_FREQUENCY_RESET = FREQ_BITS'(2);

    typedef enum logic [FUNC_BITS-1:0] {
        FUNC_DATA_OBSERVED = 3'd0,
        FUNC_BYTES_READ    = 3'd1,
        FUNC_UPDATE_SENT   = 3'd2,
        FUNC_UPDATE_LOST   = 3'd3,
        FUNC_PEER_BLOCKED  = 3'd4
    } func_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_VIOLATION = 2'd1,
        STATUS_OVERFLOW  = 2'd2
    } status_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_INITIAL_WINDOW       = 3'd0,
        CFG_RTT_FREQUENCY        = 3'd1,
        CFG_WINDOW_FREQUENCY     = 3'd2,
        CFG_DISABLE_TIME_UPDATES = 3'd3,
        CFG_AUTOTUNE             = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [FUNC_BITS-1:0]   func;
        logic [OFFSET_BITS-1:0] amount;
        logic [OFFSET_BITS-1:0] prior_offset;
        logic [TIME_BITS-1:0]   now_us;
        logic [RTT_BITS-1:0]    rtt_us;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic                   update_pending;
        logic [OFFSET_BITS-1:0] max_data_value;
        logic [OFFSET_BITS-1:0] receive_credit;
    } out_item_t;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] initial_window;
        logic [FREQ_BITS-1:0]   rtt_frequency;
        logic [FREQ_BITS-1:0]   window_frequency;
        logic                   disable_time_updates;
        logic                   autotune;
    } cfg_t;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] read_total;
        logic [OFFSET_BITS-1:0] observed_total;
        logic [OFFSET_BITS-1:0] advertised_limit;
        logic [OFFSET_BITS-1:0] window_size;
        logic [TIME_BITS-1:0]   last_update_time;
        logic                   has_last_update;
        logic                   pending_flag;
    } flow_state_t;

    // Saturating add at the offset width.
    function automatic logic [OFFSET_BITS-1:0] sat_add(
        input logic [OFFSET_BITS-1:0] a,
        input logic [OFFSET_BITS-1:0] b
    );
        logic [OFFSET_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[OFFSET_BITS] ? OFFSET_MAX : s[OFFSET_BITS-1:0];
    endfunction

endpackage

[hw/rtl/crfc_update.sv]
// Next-state and result logic for one flow-control event.
// Purely combinational; uses crfc_pkg.
module crfc_update
    import crfc_pkg::*;
(
    input  cfg_t        cfg,
    input  flow_state_t cur,
    input  in_item_t    item,
    output flow_state_t nxt,
    output out_item_t   result
);

    localparam int PROD_BITS = FREQ_BITS + RTT_BITS;
    localparam int CMP_BITS  = (TIME_BITS > PROD_BITS) ? TIME_BITS : PROD_BITS;

    logic [OFFSET_BITS-1:0]           diff;
    logic [OFFSET_BITS:0]             obs_sum;
    logic [OFFSET_BITS:0]             read_sum;
    logic [OFFSET_BITS-1:0]           read_new;
    logic [TIME_BITS-1:0]             elapsed;
    logic                             time_after;
    logic [PROD_BITS-1:0]             rtt_limit;
    logic                             time_due;
    logic [OFFSET_BITS-1:0]           remaining;
    logic [OFFSET_BITS-1:0]           consumed;
    logic [OFFSET_BITS+FREQ_BITS-1:0] consumed_scaled;
    logic                             window_due;
    logic                             update_due;
    logic                             fast_update;
    logic [OFFSET_BITS-1:0]           window_doubled;
    logic [OFFSET_BITS-1:0]           max_sum;
    status_t                          status;

    always_comb begin
        diff     = (item.amount > item.prior_offset) ? item.amount - item.prior_offset : '0;
        obs_sum  = {1'b0, cur.observed_total} + {1'b0, diff};
        read_sum = {1'b0, cur.read_total} + {1'b0, item.amount};
        read_new = read_sum[OFFSET_BITS-1:0];

        elapsed    = item.now_us - cur.last_update_time;
        time_after = cur.has_last_update && (item.now_us > cur.last_update_time);
        rtt_limit  = PROD_BITS'(cfg.rtt_frequency) * PROD_BITS'(item.rtt_us);
        time_due   = !cfg.disable_time_updates && !cfg.autotune && time_after &&
                     (CMP_BITS'(elapsed) > CMP_BITS'(rtt_limit));

        // consumed > window / freq  is the same as  consumed * freq > window
        remaining       = (cur.advertised_limit > read_new) ?
                          cur.advertised_limit - read_new : '0;
        consumed        = cur.window_size - remaining;
        consumed_scaled = (OFFSET_BITS+FREQ_BITS)'(consumed) *
                          (OFFSET_BITS+FREQ_BITS)'(cfg.window_frequency);
        window_due      = (remaining <= cur.window_size) && (cfg.window_frequency != '0) &&
                          (consumed_scaled > (OFFSET_BITS+FREQ_BITS)'(cur.window_size));

        update_due = (sat_add(read_new, cur.window_size) != cur.advertised_limit) &&
                     (time_due || window_due);

        fast_update    = time_after && (item.rtt_us != '0) &&
                         (CMP_BITS'(elapsed) < CMP_BITS'({item.rtt_us, 1'b0}));
        window_doubled = (cur.window_size > (OFFSET_MAX >> 1)) ? OFFSET_MAX :
                         {cur.window_size[OFFSET_BITS-2:0], 1'b0};

        nxt    = cur;
        status = STATUS_OK;
        unique case (func_t'(item.func))
            FUNC_DATA_OBSERVED: begin
                if (obs_sum[OFFSET_BITS]) begin
                    status = STATUS_OVERFLOW;
                end else if (obs_sum[OFFSET_BITS-1:0] > cur.advertised_limit) begin
                    status = STATUS_VIOLATION;
                end else begin
                    nxt.observed_total = obs_sum[OFFSET_BITS-1:0];
                end
            end
            FUNC_BYTES_READ: begin
                if (read_sum[OFFSET_BITS]) begin
                    status = STATUS_OVERFLOW;
                end else begin
                    nxt.read_total = read_new;
                    if (!cur.pending_flag && update_due) begin
                        nxt.pending_flag = 1'b1;
                        if (cfg.autotune && fast_update) begin
                            nxt.window_size = window_doubled;
                        end
                    end
                end
            end
            FUNC_UPDATE_SENT: begin
                nxt.advertised_limit = item.amount;
                nxt.last_update_time = item.now_us;
                nxt.has_last_update  = 1'b1;
                nxt.pending_flag     = 1'b0;
            end
            FUNC_UPDATE_LOST, FUNC_PEER_BLOCKED: begin
                nxt.pending_flag = 1'b1;
            end
            default: begin
            end
        endcase

        max_sum = sat_add(nxt.read_total, nxt.window_size);
        if (nxt.advertised_limit > max_sum) begin
            max_sum = nxt.advertised_limit;
        end

        result.status         = status;
        result.update_pending = nxt.pending_flag;
        result.max_data_value = max_sum;
        result.receive_credit = (nxt.advertised_limit > nxt.read_total) ?
                                nxt.advertised_limit - nxt.read_total : '0;
    end

endmodule

[hw/rtl/conn_receive_flow_control_core.sv]
// Top level of the receive-side connection flow-control core.
// Input register, event logic (crfc_update), result register; uses crfc_pkg.
//
//   port group   direction  handshake            payload
//   s_           in         s_valid / s_ready    s_data  (in_item_t)
//   m_           out        m_valid / m_ready    m_data  (out_item_t)
//   cfg_         in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One event per cycle while the result is not stalled: an event is captured in
// the input register, is processed in a single pass against the counter state
// and lands in the result register.
// The counter state updates on the same edge as the result register, so the next
// event sees it at once. A stalled result holds the input register, which holds s_ready.
// Reset is synchronous; the configuration port is always ready.
module conn_receive_flow_control_core
    import crfc_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  in_item_t                  s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output out_item_t                 m_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    logic        in_valid_reg;
    in_item_t    in_item_reg;
    logic        out_valid_reg;
    out_item_t   out_item_reg;
    cfg_t        cfg_reg;
    flow_state_t state_reg;
    flow_state_t state_next;
    out_item_t   result_next;
    logic        advance;
    logic        cfg_write;

    crfc_update u_update (
        .cfg    (cfg_reg),
        .cur    (state_reg),
        .item   (in_item_reg),
        .nxt    (state_next),
        .result (result_next)
    );

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_item_reg;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
        if (advance) begin
            out_item_reg <= result_next;
        end
    end

    // Counter state and configuration; a write of the initial window reloads both limits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.initial_window       <= INITIAL_WINDOW_RESET;
            cfg_reg.rtt_frequency        <= RTT_FREQUENCY_RESET;
            cfg_reg.window_frequency     <= WINDOW_FREQUENCY_RESET;
            cfg_reg.disable_time_updates <= 1'b0;
            cfg_reg.autotune             <= 1'b0;
            state_reg.read_total         <= '0;
            state_reg.observed_total     <= '0;
            state_reg.advertised_limit   <= INITIAL_WINDOW_RESET;
            state_reg.window_size        <= INITIAL_WINDOW_RESET;
            state_reg.last_update_time   <= '0;
            state_reg.has_last_update    <= 1'b0;
            state_reg.pending_flag       <= 1'b0;
        end else begin
            if (advance) begin
                state_reg <= state_next;
            end
            if (cfg_write) begin
                unique case (cfg_index)
                    CFG_INITIAL_WINDOW: begin
                        cfg_reg.initial_window     <= cfg_data[OFFSET_BITS-1:0];
                        state_reg.window_size      <= cfg_data[OFFSET_BITS-1:0];
                        state_reg.advertised_limit <= cfg_data[OFFSET_BITS-1:0];
                    end
                    CFG_RTT_FREQUENCY: begin
                        cfg_reg.rtt_frequency <= cfg_data[FREQ_BITS-1:0];
                    end
                    CFG_WINDOW_FREQUENCY: begin
                        cfg_reg.window_frequency <= cfg_data[FREQ_BITS-1:0];
                    end
                    CFG_DISABLE_TIME_UPDATES: begin
                        cfg_reg.disable_time_updates <= cfg_data[0];
                    end
                    CFG_AUTOTUNE: begin
                        cfg_reg.autotune <= cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for conn_receive_flow_control_core: credit events in, reports out.
// Predicts every report in-line from its own copy of the counters; depends on crfc_pkg only.
module testbench;
    import crfc_pkg::*;

    localparam logic [FUNC_BITS-1:0]   FUNC_RESERVED_LO = 3'd5;
    localparam logic [FUNC_BITS-1:0]   FUNC_RESERVED_HI = 3'd7;
    localparam int unsigned            MAX_IDLE         = 11;
    localparam logic [OFFSET_BITS-1:0] SPAN_CAP         = OFFSET_BITS'(1) << 40;
    localparam logic [OFFSET_BITS-1:0] SPAN_EMPTY_WIN   = OFFSET_BITS'(1) << 16;

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      s_valid   = 1'b0;
    logic                      s_ready;
    in_item_t                  s_data    = '0;
    logic                      m_valid;
    logic                      m_ready   = 1'b0;
    out_item_t                 m_data;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    cfg_t        regs;
    flow_state_t fs;
    in_item_t    queued_events[$];
    out_item_t   awaited_reports[$];
    int unsigned fail_count = 0;
    bit          src_idles  = 1'b0;
    bit          snk_stalls = 1'b0;
    int unsigned src_hold   = 0;
    int unsigned snk_hold   = 0;

    // running picture of the traffic, used to keep random events well-formed
    logic [OFFSET_BITS-1:0] read_tally    = '0;
    logic [OFFSET_BITS-1:0] stream_offset = '0;
    logic [TIME_BITS-1:0]   clock_us      = '0;

    conn_receive_flow_control_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    function automatic logic [OFFSET_BITS-1:0] add_capped(input logic [OFFSET_BITS-1:0] a,
                                                         input logic [OFFSET_BITS-1:0] b);
        return (a > OFFSET_MAX - b) ? OFFSET_MAX : a + b;
    endfunction

    function automatic void credit_reset();
        regs.initial_window       = INITIAL_WINDOW_RESET;
        regs.rtt_frequency        = RTT_FREQUENCY_RESET;
        regs.window_frequency     = WINDOW_FREQUENCY_RESET;
        regs.disable_time_updates = 1'b0;
        regs.autotune             = 1'b0;
        fs                  = '0;
        fs.advertised_limit = regs.initial_window;
        fs.window_size      = regs.initial_window;
    endfunction

    function automatic void reg_apply(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] val);
        case (idx)
            CFG_INITIAL_WINDOW: begin
                regs.initial_window = val;
                fs.window_size      = val;
                fs.advertised_limit = val;
            end
            CFG_RTT_FREQUENCY:        regs.rtt_frequency        = val[FREQ_BITS-1:0];
            CFG_WINDOW_FREQUENCY:     regs.window_frequency     = val[FREQ_BITS-1:0];
            CFG_DISABLE_TIME_UPDATES: regs.disable_time_updates = val[0];
            CFG_AUTOTUNE:             regs.autotune             = val[0];
            default: ;
        endcase
    endfunction

    function automatic bit update_wanted(input logic [TIME_BITS-1:0] now,
                                         input logic [RTT_BITS-1:0] rtt);
        logic [OFFSET_BITS-1:0] left;
        logic [OFFSET_BITS-1:0] used;
        logic [63:0]            gap;
        if (add_capped(fs.read_total, fs.window_size) == fs.advertised_limit)
            return 1'b0;
        gap = now - fs.last_update_time;
        if (!regs.disable_time_updates && !regs.autotune && fs.has_last_update
                && now > fs.last_update_time && gap > regs.rtt_frequency * 64'(rtt))
            return 1'b1;
        left = fs.advertised_limit > fs.read_total ? fs.advertised_limit - fs.read_total : '0;
        if (left > fs.window_size || regs.window_frequency == 0)
            return 1'b0;
        used = fs.window_size - left;
        return used > fs.window_size / regs.window_frequency;
    endfunction

    function automatic void grow_window(input logic [TIME_BITS-1:0] now,
                                        input logic [RTT_BITS-1:0] rtt);
        logic [63:0] gap;
        gap = now - fs.last_update_time;
        // double only when updates come faster than two round trips
        if (fs.has_last_update && rtt != 0 && now > fs.last_update_time && gap < 2 * 64'(rtt))
            fs.window_size = fs.window_size > (OFFSET_MAX >> 1) ? OFFSET_MAX
                                                                : fs.window_size << 1;
    endfunction

    function automatic out_item_t credit_step(input in_item_t ev);
        logic [OFFSET_BITS-1:0] diff;
        logic [OFFSET_BITS-1:0] total;
        status_t                st;
        out_item_t              res;
        st = STATUS_OK;
        case (ev.func)
            FUNC_DATA_OBSERVED: begin
                diff = ev.amount > ev.prior_offset ? ev.amount - ev.prior_offset : '0;
                if (fs.observed_total > OFFSET_MAX - diff)
                    st = STATUS_OVERFLOW;
                else if (fs.observed_total + diff > fs.advertised_limit)
                    st = STATUS_VIOLATION;
                else
                    fs.observed_total = fs.observed_total + diff;
            end
            FUNC_BYTES_READ: begin
                if (fs.read_total > OFFSET_MAX - ev.amount) begin
                    st = STATUS_OVERFLOW;
                end else begin
                    fs.read_total = fs.read_total + ev.amount;
                    if (!fs.pending_flag && update_wanted(ev.now_us, ev.rtt_us)) begin
                        fs.pending_flag = 1'b1;
                        if (regs.autotune)
                            grow_window(ev.now_us, ev.rtt_us);
                    end
                end
            end
            FUNC_UPDATE_SENT: begin
                fs.advertised_limit = ev.amount;
                fs.last_update_time = ev.now_us;
                fs.has_last_update  = 1'b1;
                fs.pending_flag     = 1'b0;
            end
            FUNC_UPDATE_LOST, FUNC_PEER_BLOCKED: fs.pending_flag = 1'b1;
            default: ;
        endcase
        total              = add_capped(fs.read_total, fs.window_size);
        res.status         = st;
        res.update_pending = fs.pending_flag;
        res.max_data_value = fs.advertised_limit > total ? fs.advertised_limit : total;
        res.receive_credit = fs.advertised_limit > fs.read_total
                           ? fs.advertised_limit - fs.read_total : '0;
        return res;
    endfunction

    function automatic int unsigned idle_draw(input bit on);
        return on ? $urandom_range(0, MAX_IDLE) : 0;
    endfunction

    function automatic logic [OFFSET_BITS-1:0] pick_upto(input logic [OFFSET_BITS-1:0] top);
        logic [63:0] r;
        r = {$urandom, $urandom};
        return OFFSET_BITS'(r % (64'(top) + 64'd1));
    endfunction

    function automatic in_item_t credit_event(input logic [FUNC_BITS-1:0]   f,
                                              input logic [OFFSET_BITS-1:0] amount,
                                              input logic [OFFSET_BITS-1:0] prior,
                                              input logic [TIME_BITS-1:0]   now,
                                              input logic [RTT_BITS-1:0]    rtt);
        in_item_t ev;
        ev.func         = f;
        ev.amount       = amount;
        ev.prior_offset = prior;
        ev.now_us       = now;
        ev.rtt_us       = rtt;
        return ev;
    endfunction

    function automatic in_item_t random_event(input logic [OFFSET_BITS-1:0] span,
                                              input logic [RTT_BITS-1:0]    rtt_nom);
        in_item_t    ev;
        int unsigned pick;
        pick     = $urandom_range(0, 99);
        clock_us = clock_us + TIME_BITS'($urandom_range(0, 3 * rtt_nom + 1));
        ev.func         = FUNC_BYTES_READ;
        ev.amount       = '0;
        ev.prior_offset = OFFSET_BITS'({$urandom, $urandom});
        ev.now_us       = clock_us;
        ev.rtt_us       = ($urandom_range(0, 99) == 0) ? '1 : rtt_nom;
        if (pick < 10) begin
            // noise: every field random; a noisy read either overflows or reads nothing, so the tally holds
            ev = $bits(in_item_t)'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                    $urandom, $urandom});
            ev.func = FUNC_BITS'($urandom_range(0, 7));
            if (ev.func == FUNC_BYTES_READ)
                ev.amount = read_tally != 0 ? OFFSET_MAX : '0;
        end else if (pick < 45) begin
            ev.amount  = pick_upto(span >> 1);
            read_tally = read_tally + ev.amount;
        end else if (pick < 70) begin
            ev.func = FUNC_DATA_OBSERVED;
            if ($urandom_range(0, 9) == 0)
                stream_offset = '0;
            ev.prior_offset = stream_offset;
            ev.amount = ($urandom_range(0, 4) == 0) ? pick_upto(stream_offset)
                      : add_capped(stream_offset, pick_upto(span >> 2));
            if (ev.amount > stream_offset)
                stream_offset = ev.amount;
        end else if (pick < 85) begin
            ev.func   = FUNC_UPDATE_SENT;
            ev.amount = add_capped(read_tally, pick_upto(span));
        end else begin
            ev.func   = pick < 93 ? FUNC_UPDATE_LOST : FUNC_PEER_BLOCKED;
            ev.amount = OFFSET_BITS'({$urandom, $urandom});
        end
        return ev;
    endfunction

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        reg_apply(idx, val);
        cfg_valid <= 1'b0;
    endtask

    // sample at the falling edge so queue and valid state have settled
    task automatic drain();
        while (queued_events.size() != 0 || s_valid || awaited_reports.size() != 0)
            @(negedge aclk);
    endtask

    task automatic run_phase(input logic [OFFSET_BITS-1:0] iw,
                             input logic [FREQ_BITS-1:0]   rtt_freq,
                             input logic [FREQ_BITS-1:0]   win_freq,
                             input bit                     no_time,
                             input bit                     tune,
                             input logic [RTT_BITS-1:0]    rtt_nom,
                             input int unsigned            count,
                             input bit                     src_on,
                             input bit                     snk_on);
        logic [OFFSET_BITS-1:0] span;
        write_reg(CFG_INITIAL_WINDOW, iw);
        write_reg(CFG_RTT_FREQUENCY, CFG_DATA_BITS'(rtt_freq));
        write_reg(CFG_WINDOW_FREQUENCY, CFG_DATA_BITS'(win_freq));
        write_reg(CFG_DISABLE_TIME_UPDATES, CFG_DATA_BITS'(no_time));
        write_reg(CFG_AUTOTUNE, CFG_DATA_BITS'(tune));
        span          = iw == 0 ? SPAN_EMPTY_WIN : (iw > SPAN_CAP ? SPAN_CAP : iw);
        read_tally    = fs.read_total;
        stream_offset = '0;
        src_idles     = src_on;
        snk_stalls    = snk_on;
        repeat (count)
            queued_events.push_back(random_event(span, rtt_nom));
        drain();
    endtask

    // driver: predict on each transfer, then present the next event after its gap
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_hold = 0;
        end else begin
            if (s_valid && s_ready) begin
                awaited_reports.push_back(credit_step(s_data));
                src_hold = idle_draw(src_idles);
            end
            if (!s_valid || s_ready) begin
                if (src_hold != 0) begin
                    src_hold--;
                    s_valid <= 1'b0;
                end else if (queued_events.size() != 0) begin
                    s_data  <= queued_events.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each report with the oldest prediction
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_reports.size() == 0) begin
                $error("report received with no event awaiting it");
                fail_count++;
            end else begin
                want = awaited_reports.pop_front();
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_data.status);
                    fail_count++;
                end
                if (m_data.update_pending !== want.update_pending) begin
                    $error("update_pending: expected %0d, got %0d",
                           want.update_pending, m_data.update_pending);
                    fail_count++;
                end
                if (m_data.max_data_value !== want.max_data_value) begin
                    $error("max_data_value: expected %0h, got %0h",
                           want.max_data_value, m_data.max_data_value);
                    fail_count++;
                end
                if (m_data.receive_credit !== want.receive_credit) begin
                    $error("receive_credit: expected %0h, got %0h",
                           want.receive_credit, m_data.receive_credit);
                    fail_count++;
                end
            end
            snk_hold = idle_draw(snk_stalls);
        end
        if (snk_hold != 0) begin
            snk_hold--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        credit_reset();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        src_idles  = 1'b1;
        snk_stalls = 1'b1;

        // directed events against the reset register values
        queued_events.push_back(credit_event(FUNC_DATA_OBSERVED, 62'd1000, '0, 48'd0, 24'd0));
        queued_events.push_back(credit_event(FUNC_DATA_OBSERVED, 62'd500, 62'd800, 48'd1, 24'd0));
        queued_events.push_back(credit_event(FUNC_DATA_OBSERVED, INITIAL_WINDOW_RESET + 62'd1,
                                             62'd1000, 48'd2, 24'd0));
        queued_events.push_back(credit_event(FUNC_DATA_OBSERVED, OFFSET_MAX, '0, 48'd3, 24'd0));
        queued_events.push_back(credit_event(FUNC_DATA_OBSERVED, OFFSET_MAX, OFFSET_MAX,
                                             48'd4, 24'd0));
        queued_events.push_back(credit_event(FUNC_BYTES_READ, '0, '0, 48'd10, 24'd5));
        queued_events.push_back(credit_event(FUNC_BYTES_READ, 62'd600000, '0, 48'd20, 24'd5));
        queued_events.push_back(credit_event(FUNC_BYTES_READ, 62'd10, '0, 48'd30, 24'd5));
        queued_events.push_back(credit_event(FUNC_UPDATE_SENT, 62'd600010 + INITIAL_WINDOW_RESET,
                                             '0, 48'd100, 24'd5));
        queued_events.push_back(credit_event(FUNC_BYTES_READ, 62'd100, '0, 48'd300, 24'd50));
        // advertise below what has been read: credit clamps to zero
        queued_events.push_back(credit_event(FUNC_UPDATE_SENT, '0, '0, 48'd400, 24'd50));
        queued_events.push_back(credit_event(FUNC_BYTES_READ, 62'd5, '0, 48'd401, 24'd0));
        queued_events.push_back(credit_event(FUNC_UPDATE_LOST, '0, '0, 48'd402, 24'd50));
        queued_events.push_back(credit_event(FUNC_PEER_BLOCKED, '0, '0, 48'd403, 24'd50));
        for (int f = FUNC_RESERVED_LO; f <= FUNC_RESERVED_HI; f++)
            queued_events.push_back(credit_event(FUNC_BITS'(f),
                                                 OFFSET_BITS'({$urandom, $urandom}),
                                                 OFFSET_BITS'({$urandom, $urandom}),
                                                 TIME_BITS'({$urandom, $urandom}),
                                                 RTT_BITS'($urandom)));
        queued_events.push_back(credit_event(FUNC_BYTES_READ, OFFSET_MAX, OFFSET_MAX, '1, '1));
        queued_events.push_back(credit_event(FUNC_UPDATE_SENT, OFFSET_MAX, '0, '1, '1));
        queued_events.push_back(credit_event(FUNC_BYTES_READ, 62'd1, '0, '0, '1));
        queued_events.push_back(credit_event(FUNC_DATA_OBSERVED, OFFSET_MAX - 62'd1,
                                             OFFSET_MAX - 62'd2, '1, '1));
        drain();

        run_phase(INITIAL_WINDOW_RESET, RTT_FREQUENCY_RESET, WINDOW_FREQUENCY_RESET,
                  1'b0, 1'b0, 24'd2000, 165, 1'b1, 1'b1);
        run_phase(OFFSET_MAX, 8'd255, 8'd255, 1'b1, 1'b1, 24'd100, 165, 1'b0, 1'b0);
        run_phase('0, 8'd0, 8'd0, 1'b0, 1'b0, 24'd500, 165, 1'b1, 1'b0);
        run_phase(OFFSET_BITS'(1) << 16, 8'd4, 8'd4, 1'b0, 1'b1, 24'd1000, 165, 1'b0, 1'b1);
        run_phase(OFFSET_BITS'(4096), 8'd2, 8'd1, 1'b0, 1'b0, 24'd300, 165, 1'b1, 1'b1);
        run_phase(pick_upto(OFFSET_BITS'(1) << 24), FREQ_BITS'($urandom_range(0, 255)),
                  FREQ_BITS'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), RTT_BITS'($urandom_range(1, 5000)), 165,
                  1'b1, 1'b1);

        repeat (4) @(posedge aclk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
